// ----- hw/rtl/imvn_pkg.sv -----
package imvn_pkg;

	localparam int MaxPixels = 65536;
	localparam int CountW    = 17;
	localparam int SumW      = 24;
	localparam int SqW       = 32;
	localparam int NumW      = 46;
	localparam int RootW     = 15;

	localparam logic [CountW-1:0] CountFull = CountW'(MaxPixels);

	// Result kind codes
	localparam logic KindStats = 1'b0;
	localparam logic KindNorm  = 1'b1;

	// Pass codes on the mode field
	localparam logic ModeAccum = 1'b0;
	localparam logic ModeNorm  = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       acc;        // accumulate the accepted pixel
		logic       close_pass; // snapshot accumulators and clear them
		logic       div_step;   // one quotient bit of the mean
		logic [2:0] div_bit;
		logic       mul1;       // mean*mean and mean*sum
		logic       mul2;       // count*mean^2
		logic       fin_stat;   // form V, store it, load the statistics result
		logic       start_norm; // latch |pixel - mean| and its sign
		logic       nsq;        // numerator mag^2 * 2^30
		logic       root_step;  // one bit of the quotient root
		logic [3:0] root_bit;
		logic       fin_norm;   // load the normalized result
	} imvn_cmd_t;

endpackage

// ----- hw/rtl/imvn_ctrl.sv -----
module imvn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               mode,
	input  logic               last,
	input  logic               out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output imvn_pkg::imvn_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_VSUM,
		ST_NSQ,
		ST_ROOT,
		ST_NFIN
	} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       accept;

	// Take items only when idle and the result slot is free or draining
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Decode commands
	always_comb begin
		cmd            = '0;
		cmd.div_bit    = cnt_q[2:0];
		cmd.root_bit   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.acc        = accept && (mode == imvn_pkg::ModeAccum);
				cmd.close_pass = accept && (mode == imvn_pkg::ModeAccum) && last;
				cmd.start_norm = accept && (mode == imvn_pkg::ModeNorm);
			end
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_MUL1: cmd.mul1      = 1'b1;
			ST_MUL2: cmd.mul2      = 1'b1;
			ST_VSUM: cmd.fin_stat  = 1'b1;
			ST_NSQ:  cmd.nsq       = 1'b1;
			ST_ROOT: cmd.root_step = 1'b1;
			ST_NFIN: cmd.fin_norm  = 1'b1;
			default: cmd = '0;
		endcase
	end

	// Sequence the passes and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (mode == imvn_pkg::ModeNorm)) begin
						state_q <= ST_NSQ;
					end else if (accept && last) begin
						state_q <= ST_DIV;
						cnt_q   <= 4'd7;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_VSUM;
				ST_VSUM: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_NSQ: begin
					cnt_q   <= 4'(imvn_pkg::RootW - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						state_q <= ST_NFIN;
				end
				ST_NFIN: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/imvn_dp.sv -----
module imvn_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  imvn_pkg::imvn_cmd_t cmd,
	input  logic [7:0]          pixel,
	output logic                result_kind,
	output logic [7:0]          mean_value,
	output logic [31:0]         variance_sum,
	output logic [16:0]         pixel_total,
	output logic                overflow,
	output logic signed [15:0]  norm_value
);

	// Accumulators
	logic [imvn_pkg::CountW-1:0] cnt_q;
	logic [imvn_pkg::SumW-1:0]   sum_q;
	logic [imvn_pkg::SqW-1:0]    sq_q;
	logic                        ovf_q;
	logic [imvn_pkg::CountW-1:0] cnt_nxt;
	logic [imvn_pkg::SumW-1:0]   sum_nxt;
	logic [imvn_pkg::SqW-1:0]    sq_nxt;
	logic                        ovf_nxt;

	// Statistics working registers
	logic [imvn_pkg::CountW-1:0] n_q;
	logic [imvn_pkg::SumW-1:0]   tsum_q;
	logic [imvn_pkg::SumW-1:0]   rem_q;
	logic [imvn_pkg::SqW-1:0]    tsq_q;
	logic                        tovf_q;
	logic [7:0]                  mean_q;
	logic [15:0]                 mm_q;
	logic [31:0]                 ms_q;
	logic [31:0]                 nmm_q;
	logic [24:0]                 div_sub;

	// Stored statistics
	logic [7:0]  st_mean_q;
	logic [31:0] st_var_q;

	// Normalize working registers
	logic                         neg_q;
	logic [7:0]                   mag_q;
	logic [imvn_pkg::NumW-1:0]    num_q;
	logic [63:0]                  s_q;
	logic [47:0]                  t_q;
	logic [imvn_pkg::RootW-1:0]   q_q;
	logic [63:0]                  trial;
	logic [15:0]                  norm_mag;

	// Next accumulator values for an accepted pixel
	always_comb begin
		cnt_nxt = cnt_q;
		sum_nxt = sum_q;
		sq_nxt  = sq_q;
		ovf_nxt = ovf_q;
		if (cnt_q == imvn_pkg::CountFull) begin
			ovf_nxt = 1'b1;
		end else begin
			cnt_nxt = cnt_q + 1'b1;
			sum_nxt = sum_q + imvn_pkg::SumW'(pixel);
			sq_nxt  = sq_q + imvn_pkg::SqW'(pixel * pixel);
		end
	end

	assign div_sub  = 25'(n_q) << cmd.div_bit;
	assign trial    = s_q + (64'(t_q) << (5'(cmd.root_bit) + 5'd1))
		+ (64'(st_var_q) << {cmd.root_bit, 1'b0});
	assign norm_mag = {1'b0, q_q};

	// Hold accumulators and stored statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			ovf_q     <= 1'b0;
			st_mean_q <= '0;
			st_var_q  <= '0;
		end else begin
			if (cmd.close_pass) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.acc) begin
				cnt_q <= cnt_nxt;
				sum_q <= sum_nxt;
				sq_q  <= sq_nxt;
				ovf_q <= ovf_nxt;
			end
			if (cmd.fin_stat) begin
				st_mean_q <= mean_q;
				st_var_q  <= tsq_q + nmm_q - {ms_q[30:0], 1'b0};
			end
		end
	end

	// Snapshot, mean division, products, and the quotient root
	always_ff @(posedge clk) begin
		if (cmd.close_pass) begin
			n_q    <= cnt_nxt;
			tsum_q <= sum_nxt;
			rem_q  <= sum_nxt;
			tsq_q  <= sq_nxt;
			tovf_q <= ovf_nxt;
			mean_q <= '0;
		end
		if (cmd.div_step && (n_q != '0) && (div_sub <= 25'(rem_q))) begin
			rem_q              <= rem_q - div_sub[23:0];
			mean_q[cmd.div_bit] <= 1'b1;
		end
		if (cmd.mul1) begin
			mm_q <= mean_q * mean_q;
			ms_q <= 32'(mean_q * tsum_q);
		end
		if (cmd.mul2)
			nmm_q <= 32'(n_q * mm_q);
		if (cmd.start_norm) begin
			neg_q <= pixel < st_mean_q;
			mag_q <= (pixel < st_mean_q) ? (st_mean_q - pixel) : (pixel - st_mean_q);
		end
		if (cmd.nsq) begin
			num_q <= {16'(mag_q * mag_q), 30'd0};
			s_q   <= '0;
			t_q   <= '0;
			q_q   <= '0;
		end
		if (cmd.root_step && (trial <= 64'(num_q))) begin
			s_q               <= trial;
			t_q               <= t_q + (48'(st_var_q) << cmd.root_bit);
			q_q[cmd.root_bit] <= 1'b1;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.fin_stat) begin
			result_kind  <= imvn_pkg::KindStats;
			mean_value   <= mean_q;
			variance_sum <= tsq_q + nmm_q - {ms_q[30:0], 1'b0};
			pixel_total  <= n_q;
			overflow     <= tovf_q;
			norm_value   <= '0;
		end else if (cmd.fin_norm) begin
			result_kind  <= imvn_pkg::KindNorm;
			mean_value   <= st_mean_q;
			variance_sum <= st_var_q;
			pixel_total  <= '0;
			overflow     <= 1'b0;
			if (st_var_q == '0)
				norm_value <= '0;
			else
				norm_value <= neg_q ? (16'd0 - norm_mag) : norm_mag;
		end
	end

endmodule

// ----- hw/rtl/image_mean_variance_normalize_core.sv -----
// Channel  | handshake              | payload
// input    | in_valid / in_stall    | mode, pixel, last
// output   | out_valid / out_stall  | result_kind, mean_value, variance_sum,
//          |                        | pixel_total, overflow, norm_value
//
// Accumulate pixels without last stream one per cycle unless a held result stalls the input.
// A pixel with last runs the bit-serial mean division, then forms V in the MUL1, MUL2 and VSUM steps.
// A normalize pixel runs the NSQ step, the 15-step bit-serial quotient root, then NFIN.
// Reset clears accumulators, stored mean and V, and the result valid flag.
// Input stalls while a pass closes or a normalize runs, or while a result is held.
module image_mean_variance_normalize_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [7:0]         pixel,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [7:0]         mean_value,
	output logic [31:0]        variance_sum,
	output logic [16:0]        pixel_total,
	output logic               overflow,
	output logic signed [15:0] norm_value
);

	imvn_pkg::imvn_cmd_t cmd;

	imvn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.last      (last),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	imvn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.pixel        (pixel),
		.result_kind  (result_kind),
		.mean_value   (mean_value),
		.variance_sum (variance_sum),
		.pixel_total  (pixel_total),
		.overflow     (overflow),
		.norm_value   (norm_value)
	);

`ifndef SYNTH
	a_norm_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == imvn_pkg::ModeNorm) |=> in_stall)
		else $error("normalize item did not block the input");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_total <= 17'(imvn_pkg::MaxPixels)))
		else $error("pixel total beyond limit");

	a_norm_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == imvn_pkg::KindNorm) |-> (norm_value != 16'sh8000))
		else $error("normalized value outside saturation range");
`endif

endmodule
